FILE: hw/rtl/pkct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkct_pkg: shared types and constants for the per-key cooldown table
// Beat payload structs, field widths and the sequencer state encoding.
// ----------------------------------------------------------------------------
package pkct_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 256;
  localparam int DEFAULT_KEY_BITS    = 64;
  localparam int USER_KEY_W          = 64;
  localparam int TIME_W              = 32;
  localparam int COUNT_W             = 9;

  typedef struct packed {
    logic [USER_KEY_W-1:0] user_key;
    logic [TIME_W-1:0]     now_seconds;
  } pkct_in_t;

  typedef struct packed {
    logic               granted;
    logic               newly_added;
    logic               table_full;
    logic [COUNT_W-1:0] entry_count;
  } pkct_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SEARCH_WAIT,
    ST_PROBE_WAIT,
    ST_SHIFT,
    ST_INSERT
  } pkct_state_t;

endpackage

FILE: hw/rtl/per_key_cooldown_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_key_cooldown_table: rate limiter with one cooldown per requester key
// Sorted entry table, binary search lookup and in-place sorted insertion.
// ----------------------------------------------------------------------------
// Usage:
//   A request beat (key, current time) is taken when start is high and busy
//   is low. busy stays high until the result has been produced; the result
//   beat appears on out_data for exactly one cycle with out_valid high, and
//   the receiver has no way to hold it off. start may be raised again in the
//   cycle the result is shown.
//   The cooldown register is written on the cfg channel (cfg_ready is always
//   high); write it only while busy is low. It only affects keys inserted
//   later.
//   Operation: each search halving step reads the midpoint entry through the
//   single registered memory read port and compares its key, and a final
//   probe reads the entry at the found position. An insert then moves every
//   entry above the insert point up by one, one entry per cycle, and then
//   writes the new entry.
//   Reset clears the entry count and the cooldown register; the entry
//   storage itself is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module per_key_cooldown_table
  import pkct_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
  parameter int KEY_BITS    = DEFAULT_KEY_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  pkct_in_t          in_data,
  output logic              out_valid,
  output pkct_out_t         out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [TIME_W-1:0] cfg_data
);

  localparam int IDX_W   = $clog2(TABLE_DEPTH);
  localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
  localparam int ENTRY_W = KEY_BITS + 2 * TIME_W;
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_DEPTH);

  pkct_state_t          state_r, state_nxt;
  logic [KEY_BITS-1:0]  key_r, key_nxt;
  logic [TIME_W-1:0]    now_r, now_nxt;
  logic [CNT_W-1:0]     lo_r, lo_nxt;
  logic [CNT_W-1:0]     hi_r, hi_nxt;
  logic [CNT_W-1:0]     mid_r, mid_nxt;
  logic [CNT_W-1:0]     idx_r, idx_nxt;
  logic [CNT_W-1:0]     used_r, used_nxt;
  logic [TIME_W-1:0]    cooldown_r;
  logic                 out_valid_r, out_valid_nxt;
  pkct_out_t            out_data_r, out_data_nxt;

  logic                 wr_en, rd_en;
  logic [IDX_W-1:0]     wr_addr, rd_addr;
  logic [ENTRY_W-1:0]   wr_data, rd_data;
  logic [KEY_BITS-1:0]  rd_key;
  logic [TIME_W-1:0]    rd_last, rd_cd;
  logic [TIME_W:0]      due;
  logic                 due_ok;
  logic                 key_lt, key_eq;
  logic                 miss;
  logic [CNT_W-1:0]     mid_calc;

  pkct_mem #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (ENTRY_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_key  = rd_data[ENTRY_W-1 -: KEY_BITS];
  assign rd_last = rd_data[2*TIME_W-1 -: TIME_W];
  assign rd_cd   = rd_data[TIME_W-1:0];

  // One less-than comparator serves every search step, one equality comparator the final probe.
  assign key_lt = rd_key < key_r;
  assign key_eq = rd_key == key_r;

  // The due time is formed one bit wider so that it never wraps.
  assign due    = {1'b0, rd_last} + {1'b0, rd_cd};
  assign due_ok = due <= {1'b0, now_r};

  assign mid_calc = lo_r + ((hi_r - lo_r) >> 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= '0;
      cooldown_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        cooldown_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    now_r      <= now_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mid_r      <= mid_nxt;
    idx_r      <= idx_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    key_nxt       = key_r;
    now_nxt       = now_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    idx_nxt       = idx_r;
    used_nxt      = used_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    wr_addr       = lo_r[IDX_W-1:0];
    wr_data       = {key_r, now_r, cooldown_r};
    rd_en         = 1'b0;
    rd_addr       = lo_r[IDX_W-1:0];
    miss          = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          key_nxt   = in_data.user_key[KEY_BITS-1:0];
          now_nxt   = in_data.now_seconds;
          lo_nxt    = '0;
          hi_nxt    = used_r;
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (lo_r < hi_r) begin
          rd_en     = 1'b1;
          rd_addr   = mid_calc[IDX_W-1:0];
          mid_nxt   = mid_calc;
          state_nxt = ST_SEARCH_WAIT;
        end else if (lo_r < used_r) begin
          rd_en     = 1'b1;
          state_nxt = ST_PROBE_WAIT;
        end else begin
          miss = 1'b1;
        end
      end
      ST_SEARCH_WAIT: begin
        if (key_lt) begin
          lo_nxt = mid_r + CNT_W'(1);
        end else begin
          hi_nxt = mid_r;
        end
        state_nxt = ST_SEARCH;
      end
      ST_PROBE_WAIT: begin
        if (key_eq) begin
          wr_en         = due_ok;
          wr_data       = {key_r, now_r, rd_cd};
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{granted: due_ok, newly_added: 1'b0, table_full: 1'b0,
                            entry_count: COUNT_W'(used_r)};
          state_nxt     = ST_IDLE;
        end else begin
          miss = 1'b1;
        end
      end
      ST_SHIFT: begin
        // Data read last cycle from idx-1 moves up to idx; the next lower
        // entry is read in the same cycle.
        wr_en   = 1'b1;
        wr_addr = idx_r[IDX_W-1:0];
        wr_data = rd_data;
        idx_nxt = idx_r - CNT_W'(1);
        if (idx_r > lo_r + CNT_W'(1)) begin
          rd_en   = 1'b1;
          rd_addr = IDX_W'(idx_r - CNT_W'(2));
        end else begin
          state_nxt = ST_INSERT;
        end
      end
      ST_INSERT: begin
        wr_en         = 1'b1;
        used_nxt      = used_r + CNT_W'(1);
        out_valid_nxt = 1'b1;
        out_data_nxt  = '{granted: 1'b1, newly_added: 1'b1, table_full: 1'b0,
                          entry_count: COUNT_W'(used_r + CNT_W'(1))};
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (miss) begin
      if (used_r == FULL_COUNT) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = '{granted: 1'b0, newly_added: 1'b0, table_full: 1'b1,
                          entry_count: COUNT_W'(used_r)};
        state_nxt     = ST_IDLE;
      end else if (used_r > lo_r) begin
        rd_en     = 1'b1;
        rd_addr   = IDX_W'(used_r - CNT_W'(1));
        idx_nxt   = used_r;
        state_nxt = ST_SHIFT;
      end else begin
        state_nxt = ST_INSERT;
      end
    end
  end

  assign busy      = state_r != ST_IDLE;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A result beat only ever closes a request that was in progress.
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result beat without a request in progress");

  // The entry count never passes the table depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= FULL_COUNT)
    else $error("entry count above table depth");

  // A full-table result is never a grant and only occurs with a full table.
  a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.table_full) |->
      (!out_data.granted && !out_data.newly_added && used_r == FULL_COUNT))
    else $error("inconsistent full-table result");

  // An insert grows the table by exactly one entry.
  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INSERT) |=> (used_r == $past(used_r) + CNT_W'(1)))
    else $error("insert did not bump the entry count");

endmodule

FILE: hw/rtl/pkct_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkct_mem: entry store of the cooldown table
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pkct_mem #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
